[hdl/fatw_pkg.sv]
// Package for the allocation table entry writer: beat types, controller states,
// command/status bundles and fixed constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fatw_pkg;

    // Fixed field widths
    localparam int IDX_W      = 16;
    localparam int VAL_W      = 16;
    localparam int BADDR_W    = 13;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    // Wide enough for 2*index and index+index/2 at any index
    localparam int FULL_ADDR_W = 17;

    // Entry masks
    localparam logic [15:0] MASK_ENTRY12 = 16'h0FFF;
    localparam logic [15:0] MASK_LOW_NIB = 16'h000F;
    localparam logic [15:0] MASK_TOP_NIB = 16'hF000;
    localparam logic [15:0] MASK_BYTE    = 16'h00FF;

    // Result status codes
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // Table layout codes
    localparam logic MODE_FAT12 = 1'b0;
    localparam logic MODE_FAT16 = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0] cluster_index;
        logic [VAL_W-1:0] entry_value;
    } req_t;

    typedef struct packed {
        logic               status;
        logic [BADDR_W-1:0] byte_address;
        logic [BYTE_W-1:0]  low_byte;
        logic [BYTE_W-1:0]  high_byte;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MERGE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_en;   // zero one row of both banks
        logic accept;     // take a request beat, issue bank reads
        logic merge;      // merge read bytes, write back, load result
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_done; // last row is being cleared
        logic out_free;   // result register can take a new beat
    } sts_t;

endpackage

`default_nettype wire

[hdl/fatw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fatw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, data held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/fatw_ctrl.sv]
// Controller for the allocation table entry writer: clear, idle and merge states.
// Depends on fatw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fatw_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_ready,
    input  wire fatw_pkg::sts_t sts,
    output fatw_pkg::cmd_t    cmd
);

    fatw_pkg::state_t state_reg;
    fatw_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fatw_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fatw_pkg::ST_CLEAR:
            begin
                if (sts.clear_done)
                begin
                    state_next = fatw_pkg::ST_IDLE;
                end
            end
            fatw_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = fatw_pkg::ST_MERGE;
                end
            end
            fatw_pkg::ST_MERGE:
            begin
                if (sts.out_free)
                begin
                    state_next = fatw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fatw_pkg::ST_CLEAR;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            fatw_pkg::ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
            end
            fatw_pkg::ST_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            fatw_pkg::ST_MERGE:
            begin
                cmd.merge = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/fatw_dpath.sv]
// Datapath for the allocation table entry writer: config registers, address and
// range check, two byte banks, nibble merge and result register.
// Depends on fatw_pkg and fatw_ram.
`timescale 1ns / 1ps
`default_nettype none

module fatw_dpath #(
    parameter int TABLE_BYTES = 8192
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire fatw_pkg::cmd_t                      cmd,
    output fatw_pkg::sts_t                           sts,
    input  wire fatw_pkg::req_t                      req,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_ready,
    output fatw_pkg::rsp_t                           rsp,
    input  wire logic                                cfg_valid,
    input  wire logic [fatw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [fatw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Even bytes in one bank, odd bytes in the other; a pair hits each once
    localparam int ROWS  = (TABLE_BYTES + 1) / 2;
    localparam int ROW_W = $clog2(ROWS);
    localparam int FAW   = fatw_pkg::FULL_ADDR_W;

    // Config registers
    logic        table_mode_reg;
    logic [15:0] cluster_count_reg;

    // Request registers
    logic [ROW_W-1:0]                 even_row_reg;
    logic [ROW_W-1:0]                 odd_row_reg;
    logic [fatw_pkg::BADDR_W-1:0]     addr_reg;
    logic                             swap_reg;
    logic                             odd_idx_reg;
    logic                             reject_reg;
    logic [fatw_pkg::VAL_W-1:0]       val_reg;

    // Clear sweep
    logic [ROW_W-1:0] clr_cnt_reg;
    logic [ROW_W-1:0] clr_cnt_next;

    // Result register
    logic           rsp_valid_reg;
    fatw_pkg::rsp_t rsp_reg;
    fatw_pkg::rsp_t rsp_next;

    // Address and range check
    logic [FAW-1:0]   addr_full;
    logic [FAW-1:0]   idx_ext;
    logic [FAW-1:0]   idx_limit;
    logic [FAW:0]     pair_end;
    logic             reject;
    logic [ROW_W-1:0] odd_row;
    logic [ROW_W-1:0] even_row;

    // Bank ports
    logic [7:0]       even_rdata;
    logic [7:0]       odd_rdata;
    logic             even_we;
    logic             odd_we;
    logic [ROW_W-1:0] even_waddr;
    logic [ROW_W-1:0] odd_waddr;
    logic [7:0]       even_wdata;
    logic [7:0]       odd_wdata;

    // Merge
    logic [7:0]  old_lo;
    logic [7:0]  old_hi;
    logic [15:0] old_word;
    logic [15:0] val12;
    logic [15:0] new_word;
    logic [7:0]  new_lo;
    logic [7:0]  new_hi;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_mode_reg    <= fatw_pkg::MODE_FAT12;
            cluster_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fatw_pkg::CFG_TABLE_MODE:    table_mode_reg    <= cfg_data[0];
                fatw_pkg::CFG_CLUSTER_COUNT: cluster_count_reg <= cfg_data;
                default:                     table_mode_reg    <= table_mode_reg;
            endcase
        end
    end

    // Byte address of the pair and range check
    always_comb
    begin
        idx_ext = FAW'(req.cluster_index);
        if (table_mode_reg == fatw_pkg::MODE_FAT16)
        begin
            addr_full = {req.cluster_index, 1'b0};
        end
        else
        begin
            addr_full = idx_ext + FAW'(req.cluster_index[15:1]);
        end
        idx_limit = FAW'(cluster_count_reg) + FAW'(1);
        pair_end  = (FAW+1)'(addr_full) + (FAW+1)'(1);
        reject    = (idx_ext > idx_limit) || (pair_end >= (FAW+1)'(TABLE_BYTES));
        odd_row   = addr_full[ROW_W:1];
        even_row  = odd_row + ROW_W'(addr_full[0]);
    end

    // Capture request on accept
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            even_row_reg <= even_row;
            odd_row_reg  <= odd_row;
            addr_reg     <= addr_full[fatw_pkg::BADDR_W-1:0];
            swap_reg     <= addr_full[0];
            odd_idx_reg  <= req.cluster_index[0];
            reject_reg   <= reject;
            val_reg      <= req.entry_value;
        end
    end

    // Nibble merge of the read pair
    always_comb
    begin
        old_lo   = swap_reg ? odd_rdata  : even_rdata;
        old_hi   = swap_reg ? even_rdata : odd_rdata;
        old_word = {old_hi, old_lo};
        val12    = val_reg & fatw_pkg::MASK_ENTRY12;
        if (table_mode_reg == fatw_pkg::MODE_FAT16)
        begin
            new_word = val_reg;
        end
        else if (odd_idx_reg)
        begin
            new_word = (old_word & fatw_pkg::MASK_LOW_NIB) | {val12[11:0], 4'h0};
        end
        else
        begin
            new_word = (old_word & fatw_pkg::MASK_TOP_NIB) | val12;
        end
        new_lo = 8'(new_word & fatw_pkg::MASK_BYTE);
        new_hi = 8'((new_word >> 8) & fatw_pkg::MASK_BYTE);
    end

    // Bank write mux: clear sweep or merge write-back
    always_comb
    begin
        if (cmd.clear_en)
        begin
            even_we    = 1'b1;
            odd_we     = 1'b1;
            even_waddr = clr_cnt_reg;
            odd_waddr  = clr_cnt_reg;
            even_wdata = '0;
            odd_wdata  = '0;
        end
        else
        begin
            even_we    = cmd.merge && !reject_reg;
            odd_we     = cmd.merge && !reject_reg;
            even_waddr = even_row_reg;
            odd_waddr  = odd_row_reg;
            even_wdata = swap_reg ? new_hi : new_lo;
            odd_wdata  = swap_reg ? new_lo : new_hi;
        end
    end

    fatw_ram #(
        .WIDTH (8),
        .DEPTH (ROWS)
    ) u_even_bank (
        .clk   (clk),
        .we    (even_we),
        .waddr (even_waddr),
        .wdata (even_wdata),
        .re    (cmd.accept),
        .raddr (even_row),
        .rdata (even_rdata)
    );

    fatw_ram #(
        .WIDTH (8),
        .DEPTH (ROWS)
    ) u_odd_bank (
        .clk   (clk),
        .we    (odd_we),
        .waddr (odd_waddr),
        .wdata (odd_wdata),
        .re    (cmd.accept),
        .raddr (odd_row),
        .rdata (odd_rdata)
    );

    // Clear sweep counter
    assign clr_cnt_next = clr_cnt_reg + ROW_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_en)
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Result beat
    always_comb
    begin
        if (reject_reg)
        begin
            rsp_next.status       = fatw_pkg::STATUS_REJECT;
            rsp_next.byte_address = '0;
            rsp_next.low_byte     = '0;
            rsp_next.high_byte    = '0;
        end
        else
        begin
            rsp_next.status       = fatw_pkg::STATUS_OK;
            rsp_next.byte_address = addr_reg;
            rsp_next.low_byte     = new_lo;
            rsp_next.high_byte    = new_hi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.merge)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.merge)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Status to controller
    assign sts.clear_done = (clr_cnt_reg == ROW_W'(ROWS - 1));
    assign sts.out_free   = !rsp_valid_reg || rsp_ready;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

[hdl/fat_table_entry_writer_top.sv]
// FAT12/FAT16 allocation table entry writer, top level.
// Depends on fatw_pkg, fatw_ctrl, fatw_dpath (which uses fatw_ram).
//
// Each request beat writes one cluster entry into a zero-initialized table of
// TABLE_BYTES bytes and returns one result beat with the status, the byte
// address of the written pair and the two bytes now stored there (all zero
// with status 1 when the index is beyond cluster_count+1 or the pair would run
// past the table). The table sits in two byte banks, even and odd addresses,
// so both bytes of any pair are read together and written together: each
// entry passes through an accept state that reads the pair and a merge
// state that writes it back and loads the result register. The result
// register holds a finished beat while the next request is accepted; that
// request's merge waits until the result is taken. After reset a clearing
// pass zeroes the banks row by row, with req_ready low;
// configuration writes are taken at any time (cfg_ready is always high) but
// are meant for when the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module fat_table_entry_writer_top #(
    parameter int TABLE_BYTES = 8192
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                req_valid,
    output logic                                     req_ready,
    input  wire fatw_pkg::req_t                      req,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_ready,
    output fatw_pkg::rsp_t                           rsp,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [fatw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [fatw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    fatw_pkg::cmd_t cmd;
    fatw_pkg::sts_t sts;

    // Config registers always take a write beat
    assign cfg_ready = 1'b1;

    fatw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fatw_dpath #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

[hdl/fatw_checker.sv]
// Port-level checker for the allocation table entry writer, with its bind.
// Depends on fatw_pkg and fat_table_entry_writer_top.
`timescale 1ns / 1ps
`default_nettype none

module fatw_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            req_valid,
    input wire logic                            req_ready,
    input wire logic                            rsp_valid,
    input wire logic                            rsp_ready,
    input wire fatw_pkg::rsp_t                  rsp
);

    // A stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    // Rejected writes report zero address and bytes
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == fatw_pkg::STATUS_REJECT |->
            rsp.byte_address == '0 && rsp.low_byte == '0 && rsp.high_byte == '0)
        else $error("rejected result carries data");

    // One entry in flight: no request beat right after one is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken back to back");

    // A new result appears only out of the merge cycle
    a_rsp_after_merge: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("result appeared without a merge cycle");

endmodule

bind fat_table_entry_writer_top fatw_checker u_fatw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

[bench/fat_table_entry_writer_top_test.sv]
// Self-checking bench for fat_table_entry_writer_top: 12-bit and 16-bit entry writes,
// checked against a behavioral model of the byte table under random handshake stalls.
// Depends on fatw_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module fat_table_entry_writer_top_test;

    import fatw_pkg::*;

    localparam int TABLE_BYTES   = 8192;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int IDLE_PCT      = 28;
    localparam int CALM_FIRST    = 700;   // no idling on either side in this beat range
    localparam int CALM_LAST     = 1000;
    localparam int HOLD_AT       = 300;   // results seen before the long receiver hold-off
    localparam int HOLD_CYCLES   = 160;
    localparam int SETTLE_CYCLES = 6;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Stimulus and expectation stores
    req_t       entry_writes[$];
    rsp_t       expected_pairs[$];
    reg_write_t reg_writes[$];

    // Behavioral copy of the table and its registers
    logic [7:0]  fat_bytes [TABLE_BYTES];
    logic        model_mode;
    logic [15:0] model_clusters;

    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned fat12_writes;
    int unsigned fat16_writes;
    int unsigned rejected_writes;
    int unsigned reg_updates;
    int unsigned cycle_count = 0;

    // Receiver hold-off state
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    fat_table_entry_writer_top #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_pairs.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Apply one entry write to the table copy and return the result beat it produces
    function automatic rsp_t write_entry(req_t r);
        int unsigned idx;
        int unsigned addr;
        logic [15:0] val;
        logic [15:0] word;
        rsp_t        res;
        idx = r.cluster_index;
        val = r.entry_value;
        res = '0;
        addr = (model_mode == MODE_FAT16) ? idx * 2 : idx + idx / 2;
        // beyond the cluster range, or pair running past the table end
        if (idx > model_clusters + 1 || addr + 1 >= TABLE_BYTES)
        begin
            res.status = STATUS_REJECT;
            rejected_writes++;
            return res;
        end
        if (model_mode == MODE_FAT16)
        begin
            word = val;
            fat16_writes++;
        end
        else
        begin
            word = {fat_bytes[addr + 1], fat_bytes[addr]};
            val  = val & MASK_ENTRY12;
            // odd entries sit in the top 12 bits, even ones in the low 12
            if (idx[0])
                word = (word & MASK_LOW_NIB) | (val << 4);
            else
                word = (word & MASK_TOP_NIB) | val;
            fat12_writes++;
        end
        fat_bytes[addr]     = word[7:0];
        fat_bytes[addr + 1] = word[15:8];
        res.status       = STATUS_OK;
        res.byte_address = addr[BADDR_W-1:0];
        res.low_byte     = word[7:0];
        res.high_byte    = word[15:8];
        return res;
    endfunction

    // Request driver: predicts on every accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            req        <= '0;
            items_sent = 0;
            fat12_writes = 0;
            fat16_writes = 0;
            rejected_writes = 0;
            foreach (fat_bytes[i])
                fat_bytes[i] = '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_pairs.push_back(write_entry(req));
                items_sent++;
            end
            if (!req_valid || req_ready)
            begin
                if (entry_writes.size() != 0 &&
                    ((items_sent >= CALM_FIRST && items_sent < CALM_LAST) ||
                     $urandom_range(99) >= IDLE_PCT))
                begin
                    req       <= entry_writes.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin : hold_off
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_seen >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin : result_side
        rsp_t        want;
        string       bad;
        if (!rst_n)
        begin
            rsp_ready    <= 1'b0;
            results_seen = 0;
            mismatches   = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                results_seen++;
                if (expected_pairs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: st=%0d addr=%04h lo=%02h hi=%02h",
                                 rsp.status, rsp.byte_address, rsp.low_byte, rsp.high_byte);
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    bad  = "";
                    if (rsp.status !== want.status)             bad = {bad, " status"};
                    if (rsp.byte_address !== want.byte_address) bad = {bad, " byte_address"};
                    if (rsp.low_byte !== want.low_byte)         bad = {bad, " low_byte"};
                    if (rsp.high_byte !== want.high_byte)       bad = {bad, " high_byte"};
                    if (bad != "")
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result %0d wrong in%s:", results_seen, bad);
                            $display("  expected st=%0d addr=%04h lo=%02h hi=%02h",
                                     want.status, want.byte_address,
                                     want.low_byte, want.high_byte);
                            $display("  got      st=%0d addr=%04h lo=%02h hi=%02h",
                                     rsp.status, rsp.byte_address,
                                     rsp.low_byte, rsp.high_byte);
                        end
                    end
                end
            end
            if (hold_left != 0)
                rsp_ready <= 1'b0;
            else if (results_seen >= CALM_FIRST && results_seen < CALM_LAST)
                rsp_ready <= 1'b1;
            else
                rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Register write port
    always @(posedge clk or negedge rst_n)
    begin : reg_port
        reg_write_t w;
        if (!rst_n)
        begin
            cfg_valid      <= 1'b0;
            cfg_index      <= '0;
            cfg_data       <= '0;
            model_mode     = MODE_FAT12;
            model_clusters = '0;
            reg_updates    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TABLE_MODE:    model_mode = cfg_data[0];
                    CFG_CLUSTER_COUNT: model_clusters = cfg_data;
                    default:           ;
                endcase
                reg_updates++;
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_writes.size() != 0)
                begin
                    w = reg_writes.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= w.idx;
                    cfg_data  <= w.data;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    // Queue one register write and wait until it has been taken
    task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        reg_write_t w;
        w.idx  = idx;
        w.data = data;
        reg_writes.push_back(w);
        do
            @(negedge clk);
        while (reg_writes.size() != 0 || cfg_valid);
    endtask

    task automatic queue_entry(int unsigned idx, int unsigned val);
        req_t r;
        r.cluster_index = idx[IDX_W-1:0];
        r.entry_value   = val[VAL_W-1:0];
        entry_writes.push_back(r);
    endtask

    // Random writes, mostly inside the valid range and dense near the start
    // of the table so neighboring 12-bit entries share bytes
    task automatic queue_random(int unsigned count);
        int unsigned top_ok;
        int unsigned idx;
        int unsigned pick;
        top_ok = (model_mode == MODE_FAT16) ? TABLE_BYTES / 2 - 1 : (2 * TABLE_BYTES - 4) / 3;
        if (model_clusters + 1 < top_ok)
            top_ok = model_clusters + 1;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                idx = $urandom_range(top_ok < 63 ? top_ok : 63, 0);
            else if (pick < 80)
                idx = $urandom_range(top_ok, 0);
            else if (pick < 90)
                idx = top_ok + $urandom_range(3, 0);
            else
                idx = $urandom_range(16'hFFFF, 0);
            queue_entry(idx, $urandom_range(16'hFFFF, 0));
        end
    endtask

    // Wait for all beats to be sent and all results back, then let the pipe settle
    task automatic wait_drained();
        while (entry_writes.size() != 0 || req_valid || expected_pairs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Test sequence
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // 12-bit layout, smallest volume: only indexes 0 and 1 are legal
        set_register(CFG_TABLE_MODE, CFG_DATA_W'(MODE_FAT12));
        set_register(CFG_CLUSTER_COUNT, 16'd0);
        queue_entry(0, 16'hFFFF);
        queue_entry(1, 16'hFFFF);
        queue_entry(2, 16'h1234);
        queue_entry(16'hFFFF, 16'h0000);
        queue_random(100);
        wait_drained();

        // 12-bit layout, largest volume: nibble sharing and the table end
        set_register(CFG_CLUSTER_COUNT, 16'd65533);
        queue_entry(0, 16'h0ABC);
        queue_entry(1, 16'h0DEF);
        queue_entry(2, 16'hF123);
        queue_entry(3, 16'h0456);
        queue_entry(2, 16'h0000);
        queue_entry(4, 16'h8001);
        queue_entry(5460, 16'hFFFF);
        queue_entry(5461, 16'h1111);
        queue_entry(65534, 16'h2222);
        queue_entry(16'hFFFF, 16'hFFFF);
        queue_random(400);
        wait_drained();

        // 16-bit layout, largest volume
        set_register(CFG_TABLE_MODE, CFG_DATA_W'(MODE_FAT16));
        queue_entry(0, 16'hFFFF);
        queue_entry(1, 16'h0000);
        queue_entry(4095, 16'hA55A);
        queue_entry(4096, 16'h5AA5);
        queue_entry(16'hFFFF, 16'hFFFF);
        queue_random(400);
        wait_drained();

        // 16-bit layout, small volume
        set_register(CFG_CLUSTER_COUNT, 16'd37);
        queue_entry(38, 16'h7E81);
        queue_entry(39, 16'h8001);
        queue_random(200);
        wait_drained();

        // back to 12-bit over bytes left by 16-bit entries
        set_register(CFG_TABLE_MODE, CFG_DATA_W'(MODE_FAT12));
        queue_random(300);
        wait_drained();

        // 16-bit layout, smallest volume
        set_register(CFG_TABLE_MODE, CFG_DATA_W'(MODE_FAT16));
        set_register(CFG_CLUSTER_COUNT, 16'd0);
        queue_random(100);
        wait_drained();

        $display("checked %0d entry beats: %0d 12-bit writes, %0d 16-bit writes, %0d rejected",
                 results_seen, fat12_writes, fat16_writes, rejected_writes);
        $display("%0d register writes, one %0d-cycle receiver hold-off, %0d mismatches",
                 reg_updates, HOLD_CYCLES, mismatches);
        if (mismatches == 0 && expected_pairs.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
